### hdl/cube_vertex_rotate_project_defines.svh
// Assertion macros shared by the cube vertex projector RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef CUBE_VERTEX_ROTATE_PROJECT_DEFINES_SVH
`define CUBE_VERTEX_ROTATE_PROJECT_DEFINES_SVH
`ifndef SYNTHESIS
`define CVRP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cvrp assertion failed");
`define CVRP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cvrp assertion failed");
`else
`define CVRP_ASSERT(lbl, prop)
`define CVRP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### hdl/cvrp_pkg.sv
// Package for the cube vertex projector: state codes, command struct,
// register indexes and the Q1.15 sine table. No dependencies.
`default_nettype none
package cvrp_pkg;

    localparam int NUM_CORNERS = 8;

    typedef enum logic [2:0] {
        REG_CUBE_HALF       = 3'd0,
        REG_SCREEN_WIDTH    = 3'd1,
        REG_SCREEN_HEIGHT   = 3'd2,
        REG_FOCAL_SCALE     = 3'd3,
        REG_CAMERA_DISTANCE = 3'd4
    } cfg_reg_t;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_TRIG   = 12'b0000_0000_0010,
        S_LOAD   = 12'b0000_0000_0100,
        S_MUL1   = 12'b0000_0000_1000,
        S_MUL2   = 12'b0000_0001_0000,
        S_DEPTH  = 12'b0000_0010_0000,
        S_PMUL1  = 12'b0000_0100_0000,
        S_PMUL2  = 12'b0000_1000_0000,
        S_DIVSET = 12'b0001_0000_0000,
        S_DIV    = 12'b0010_0000_0000,
        S_DIVEND = 12'b0100_0000_0000,
        S_EMIT   = 12'b1000_0000_0000
    } state_t;

    typedef struct packed {
        logic       accept;
        logic       trig;
        logic       load;
        logic       mul1;
        logic       mul2;
        logic       depth;
        logic       pmul1;
        logic       pmul2;
        logic       divset;
        logic       div;
        logic       divend;
        logic       emit;
        logic       axis;
        logic [2:0] rot;
    } cmd_t;

    function automatic logic [91*16-1:0] build_sine();
        longint c;
        longint s;
        longint q;
        longint nc;
        longint ns;
        logic [91*16-1:0] t;
        c = 64'sd1 <<< 30;
        s = 0;
        t = '0;
        for (int k = 0; k <= 90; k++)
        begin
            q = (s + 16384) >>> 15;
            if (q > 32767)
                q = 32767;
            t[k*16 +: 16] = q[15:0];
            nc = c * 64'sd1073578288 - s * 64'sd18739379;
            ns = s * 64'sd1073578288 + c * 64'sd18739379;
            if (nc < 0)
                nc = 0;
            c = (nc + (64'sd1 <<< 29)) >>> 30;
            s = (ns + (64'sd1 <<< 29)) >>> 30;
        end
        return t;
    endfunction

    localparam logic [91*16-1:0] SINE_TAB = build_sine();

    // a in 0..449, folded into one period first
    function automatic logic signed [16:0] sin_lookup(input logic [9:0] a);
        logic [9:0]  w;
        logic [9:0]  idx;
        logic        neg;
        logic [15:0] mag;
        w = (a >= 10'd360) ? a - 10'd360 : a;
        neg = 1'b0;
        if (w <= 10'd90)
            idx = w;
        else if (w <= 10'd180)
            idx = 10'd180 - w;
        else if (w <= 10'd270)
        begin
            idx = w - 10'd180;
            neg = 1'b1;
        end
        else
        begin
            idx = 10'd360 - w;
            neg = 1'b1;
        end
        mag = SINE_TAB[idx[6:0]*16 +: 16];
        return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

endpackage
`default_nettype wire

### hdl/cube_vertex_rotate_project.sv
// Top level of the cube vertex projector: sequencer plus datapath.
// Depends on cvrp_pkg, cvrp_ctrl and cvrp_datapath.
//
// One input transaction is one display frame: with advance set the angle steps
// one degree (359 wraps to 0), then the eight cube corners are rotated about
// X, Y and Z, pushed back by camera_distance and perspective-projected, giving
// eight output transactions in corner order with last on the eighth. Frame
// length is set by the single shared multiplier (twelve products per corner for
// the rotations, four for projection) and a restoring divider producing one
// quotient bit per cycle, twelve bits for each of x and y. A new frame is taken
// once the previous frame's last point has been loaded into the output
// register. Configuration writes belong in idle.
`default_nettype none
module cube_vertex_rotate_project #(
    parameter int NUM_CORNERS = cvrp_pkg::NUM_CORNERS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic [2:0]                    cfg_index,
    input  wire logic [11:0]                   cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          advance,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [$clog2(NUM_CORNERS)-1:0]     vertex_index,
    output logic signed [11:0]                 screen_x,
    output logic signed [11:0]                 screen_y,
    output logic [8:0]                         angle_degrees,
    output logic                               last
);
    import cvrp_pkg::*;

    cmd_t                           cmd;
    logic [$clog2(NUM_CORNERS)-1:0] corner;

    cvrp_ctrl #(
        .NUM_CORNERS (NUM_CORNERS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .corner    (corner),
        .cmd       (cmd)
    );

    cvrp_datapath #(
        .NUM_CORNERS (NUM_CORNERS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .advance       (advance),
        .cmd           (cmd),
        .corner        (corner),
        .vertex_index  (vertex_index),
        .screen_x      (screen_x),
        .screen_y      (screen_y),
        .angle_degrees (angle_degrees),
        .last          (last)
    );

endmodule
`default_nettype wire

### hdl/cvrp_ctrl.sv
// Sequencer for the cube vertex projector: handshakes, corner, rotation
// and divider step counts. Depends on cvrp_pkg and the defines header.
`default_nettype none
`include "cube_vertex_rotate_project_defines.svh"
module cvrp_ctrl #(
    parameter int NUM_CORNERS = cvrp_pkg::NUM_CORNERS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [$clog2(NUM_CORNERS)-1:0]      corner,
    output cvrp_pkg::cmd_t                      cmd
);
    import cvrp_pkg::*;

    localparam int CW = $clog2(NUM_CORNERS);
    localparam logic [CW-1:0] LAST_CORNER = CW'(NUM_CORNERS - 1);

    state_t        state_reg, state_next;
    logic [CW-1:0] corner_reg, corner_next;
    logic [2:0]    rot_reg, rot_next;
    logic          axis_reg, axis_next;
    logic [3:0]    cnt_reg, cnt_next;
    logic          out_valid_reg, out_valid_next;
    logic          out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign corner    = corner_reg;

    always_comb
    begin
        state_next     = state_reg;
        corner_next    = corner_reg;
        rot_next       = rot_reg;
        axis_next      = axis_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        cmd.axis       = axis_reg;
        cmd.rot        = rot_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept  = 1'b1;
                    corner_next = '0;
                    state_next  = S_TRIG;
                end
            end
            S_TRIG:
            begin
                cmd.trig   = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                rot_next   = '0;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul2 = 1'b1;
                rot_next = rot_reg + 3'd1;
                state_next = (rot_reg == 3'd5) ? S_DEPTH : S_MUL1;
            end
            S_DEPTH:
            begin
                cmd.depth  = 1'b1;
                axis_next  = 1'b0;
                state_next = S_PMUL1;
            end
            S_PMUL1:
            begin
                cmd.pmul1  = 1'b1;
                state_next = S_PMUL2;
            end
            S_PMUL2:
            begin
                cmd.pmul2  = 1'b1;
                state_next = S_DIVSET;
            end
            S_DIVSET:
            begin
                cmd.divset = 1'b1;
                cnt_next   = 4'd11;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div  = 1'b1;
                cnt_next = cnt_reg - 4'd1;
                if (cnt_reg == 4'd0)
                    state_next = S_DIVEND;
            end
            S_DIVEND:
            begin
                cmd.divend = 1'b1;
                if (axis_reg)
                    state_next = S_EMIT;
                else
                begin
                    axis_next  = 1'b1;
                    state_next = S_PMUL1;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    corner_next    = corner_reg + CW'(1);
                    state_next     = (corner_reg == LAST_CORNER) ? S_IDLE : S_LOAD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            corner_reg    <= '0;
            rot_reg       <= '0;
            axis_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            corner_reg    <= corner_next;
            rot_reg       <= rot_next;
            axis_reg      <= axis_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `CVRP_ASSERT_NEXT(a_accept_trig, in_valid && !in_stall, state_reg == S_TRIG)
    `CVRP_ASSERT_NEXT(a_last_idle, state_reg == S_EMIT && out_free && corner_reg == LAST_CORNER,
        state_reg == S_IDLE)
    `CVRP_ASSERT(a_valid_from_emit, $rose(out_valid_reg) |-> $past(state_reg == S_EMIT))

endmodule
`default_nettype wire

### hdl/cvrp_datapath.sv
// Datapath of the cube vertex projector: configuration, angle, shared
// multiplier, rotation registers, restoring divider and output register.
// Depends on cvrp_pkg.
`default_nettype none
module cvrp_datapath #(
    parameter int NUM_CORNERS = cvrp_pkg::NUM_CORNERS
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_write,
    input  wire logic [2:0]                 cfg_index,
    input  wire logic [11:0]                cfg_data,
    input  wire logic                       advance,
    input  wire cvrp_pkg::cmd_t             cmd,
    input  wire logic [$clog2(NUM_CORNERS)-1:0] corner,
    output logic [$clog2(NUM_CORNERS)-1:0]  vertex_index,
    output logic signed [11:0]              screen_x,
    output logic signed [11:0]              screen_y,
    output logic [8:0]                      angle_degrees,
    output logic                            last
);
    import cvrp_pkg::*;

    localparam int CW = $clog2(NUM_CORNERS);

    logic [4:0]  cube_half_reg;
    logic [7:0]  screen_width_reg;
    logic [7:0]  screen_height_reg;
    logic [11:0] focal_scale_reg;
    logic [9:0]  camera_distance_reg;
    logic [8:0]  angle_reg;

    logic signed [16:0] sin_reg, cos_reg;
    logic signed [15:0] x_reg, y_reg, z_reg, y2_reg, z2_reg, x3_reg, z3_reg, ax_reg, ay_reg;
    logic signed [39:0] acc_reg;
    logic signed [19:0] az_reg;
    logic signed [31:0] num_reg;
    logic [31:0]        rem_reg, dsh_reg;
    logic [11:0]        quo_reg;
    logic               neg_reg, zero_reg, sat_reg;
    logic signed [11:0] sx_reg, sy_reg;

    logic signed [19:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [37:0] prod;
    logic signed [39:0] rsum;
    logic signed [15:0] rres;
    logic signed [39:0] psum;
    logic [19:0]        dmag;
    logic [31:0]        nmag;
    logic signed [11:0] qres;
    logic signed [15:0] hval;
    logic [9:0]         cos_angle;

    assign hval      = $signed({3'b000, cube_half_reg, 8'h00});
    assign cos_angle = {1'b0, angle_reg} + 10'd90;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (cmd.pmul1)
        begin
            mul_a = az_reg;
            mul_b = cmd.axis ? $signed({11'b0, screen_height_reg[7:1]})
                             : $signed({11'b0, screen_width_reg[7:1]});
        end
        else if (cmd.pmul2)
        begin
            mul_a = cmd.axis ? 20'(ay_reg) : 20'(ax_reg);
            mul_b = $signed({6'b0, focal_scale_reg});
        end
        else
        begin
            case (cmd.rot)
                3'd0:
                begin
                    mul_a = cmd.mul2 ? 20'(z_reg) : 20'(y_reg);
                    mul_b = cmd.mul2 ? 18'(-sin_reg) : 18'(cos_reg);
                end
                3'd1:
                begin
                    mul_a = cmd.mul2 ? 20'(z_reg) : 20'(y_reg);
                    mul_b = cmd.mul2 ? 18'(cos_reg) : 18'(sin_reg);
                end
                3'd2:
                begin
                    mul_a = cmd.mul2 ? 20'(z2_reg) : 20'(x_reg);
                    mul_b = cmd.mul2 ? 18'(sin_reg) : 18'(cos_reg);
                end
                3'd3:
                begin
                    mul_a = cmd.mul2 ? 20'(z2_reg) : 20'(x_reg);
                    mul_b = cmd.mul2 ? 18'(cos_reg) : 18'(-sin_reg);
                end
                3'd4:
                begin
                    mul_a = cmd.mul2 ? 20'(y2_reg) : 20'(x3_reg);
                    mul_b = cmd.mul2 ? 18'(-sin_reg) : 18'(cos_reg);
                end
                3'd5:
                begin
                    mul_a = cmd.mul2 ? 20'(y2_reg) : 20'(x3_reg);
                    mul_b = cmd.mul2 ? 18'(cos_reg) : 18'(sin_reg);
                end
                default:
                begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
    end

    assign prod = mul_a * mul_b;
    assign rsum = acc_reg + 40'(prod) + 40'sd16384;
    assign rres = rsum[30:15];
    assign psum = acc_reg + 40'(prod);
    assign dmag = az_reg[19] ? 20'(-az_reg) : 20'(az_reg);
    assign nmag = num_reg[31] ? 32'(-num_reg) : 32'(num_reg);

    always_comb
    begin
        if (zero_reg)
            qres = '0;
        else if (sat_reg)
            qres = neg_reg ? -12'sd2048 : 12'sd2047;
        else if (!neg_reg)
            qres = (quo_reg > 12'd2047) ? 12'sd2047 : $signed(quo_reg);
        else
            qres = (quo_reg > 12'd2048) ? -12'sd2048 : -$signed(quo_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cube_half_reg       <= 5'd3;
            screen_width_reg    <= 8'd64;
            screen_height_reg   <= 8'd48;
            focal_scale_reg     <= 12'd600;
            camera_distance_reg <= 10'd150;
            angle_reg           <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_CUBE_HALF:       cube_half_reg       <= cfg_data[4:0];
                    REG_SCREEN_WIDTH:    screen_width_reg    <= cfg_data[7:0];
                    REG_SCREEN_HEIGHT:   screen_height_reg   <= cfg_data[7:0];
                    REG_FOCAL_SCALE:     focal_scale_reg     <= cfg_data;
                    REG_CAMERA_DISTANCE: camera_distance_reg <= cfg_data[9:0];
                    default:             ;
                endcase
            end
            if (cmd.accept && advance)
                angle_reg <= (angle_reg >= 9'd359) ? 9'd0 : angle_reg + 9'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.trig)
        begin
            sin_reg <= sin_lookup({1'b0, angle_reg});
            cos_reg <= sin_lookup(cos_angle);
        end
        if (cmd.load)
        begin
            x_reg <= (corner[0] ^ corner[1]) ? hval : -hval;
            y_reg <= corner[1] ? hval : -hval;
            z_reg <= corner[2] ? hval : -hval;
        end
        if (cmd.mul1 || cmd.pmul1)
            acc_reg <= 40'(prod);
        if (cmd.mul2)
        begin
            case (cmd.rot)
                3'd0:    y2_reg <= rres;
                3'd1:    z2_reg <= rres;
                3'd2:    x3_reg <= rres;
                3'd3:    z3_reg <= rres;
                3'd4:    ax_reg <= rres;
                3'd5:    ay_reg <= rres;
                default: ;
            endcase
        end
        if (cmd.depth)
            az_reg <= 20'(z3_reg) - $signed({2'b00, camera_distance_reg, 8'h00});
        if (cmd.pmul2)
            num_reg <= psum[31:0];
        if (cmd.divset)
        begin
            // quotient sign from both operands; zero depth leaves the numerator sign
            neg_reg  <= num_reg[31] ^ az_reg[19];
            zero_reg <= (num_reg == '0);
            sat_reg  <= (nmag >= {dmag, 12'h000});
            rem_reg  <= nmag;
            dsh_reg  <= {1'b0, dmag, 11'b0};
            quo_reg  <= '0;
        end
        if (cmd.div)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_reg <= rem_reg - dsh_reg;
                quo_reg <= {quo_reg[10:0], 1'b1};
            end
            else
                quo_reg <= {quo_reg[10:0], 1'b0};
            dsh_reg <= dsh_reg >> 1;
        end
        if (cmd.divend)
        begin
            if (cmd.axis)
                sy_reg <= qres;
            else
                sx_reg <= qres;
        end
        if (cmd.emit)
        begin
            vertex_index  <= corner;
            screen_x      <= sx_reg;
            screen_y      <= sy_reg;
            angle_degrees <= angle_reg;
            last          <= (corner == CW'(NUM_CORNERS - 1));
        end
    end

endmodule
`default_nettype wire
